>>> hw/rtl/jss_pkg.sv
// ----------------------------------------------------------------------------
// jss_pkg
// Shared widths, codes and reset values of the sorted-set similarity core.
// ----------------------------------------------------------------------------
package jss_pkg;

   localparam int TOKEN_W     = 24;
   localparam int OPCODE_W    = 2;
   localparam int FRAC_W      = 16;
   localparam int SCORE_W     = 17;
   localparam int COUNT_OUT_W = 9;
   localparam int BAL_W       = 16;
   localparam int SIM_W       = 17;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 17;
   localparam int STEP_W      = 5;

   localparam logic [SCORE_W-1:0] Q16_ONE   = 17'h10000;
   localparam logic [BAL_W-1:0]   BAL_RESET = 16'd22938;
   localparam logic [SIM_W-1:0]   SIM_RESET = 17'd45220;

   localparam logic [CSR_INDEX_W-1:0] CSR_BALANCE    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIMILARITY = 1'b1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_A  = 2'd0,
      OP_PUSH_B  = 2'd1,
      OP_COMPARE = 2'd2
   } opcode_type;

endpackage

>>> hw/rtl/jss_req_if.sv
// ----------------------------------------------------------------------------
// jss_req_if
// Command channel: push to list A, push to list B, or compare.
// ----------------------------------------------------------------------------
interface jss_req_if import jss_pkg::*;;
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [TOKEN_W-1:0]  token;

   modport source (output valid, output opcode, output token, input ready);
   modport sink (input valid, input opcode, input token, output ready);
endinterface

>>> hw/rtl/jss_rsp_if.sv
// ----------------------------------------------------------------------------
// jss_rsp_if
// Result channel: one compare result per transfer.
// ----------------------------------------------------------------------------
interface jss_rsp_if import jss_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [SCORE_W-1:0]     score;
   logic                   match;
   logic [COUNT_OUT_W-1:0] common_count;
   logic                   length_rejected;
   logic                   overflowed;

   modport source (output valid, output score, output match, output common_count,
                   output length_rejected, output overflowed, input ready);
   modport sink (input valid, input score, input match, input common_count,
                 input length_rejected, input overflowed, output ready);
endinterface

>>> hw/rtl/jss_div.sv
// ----------------------------------------------------------------------------
// jss_div
// Restoring divider giving floor(num * 2^16 / den) for num <= den, one
// quotient bit per cycle after a first step that settles the integer bit.
// ----------------------------------------------------------------------------
module jss_div import jss_pkg::*; #(
   parameter int NW = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [NW-1:0]      num,
   input  logic [NW-1:0]      den,
   output logic               busy,
   output logic [SCORE_W-1:0] quo
);

   logic               busy_ff, busy_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [NW-1:0]      rem_ff, rem_in;
   logic [NW-1:0]      den_ff, den_in;
   logic [SCORE_W-1:0] quo_ff, quo_in;
   logic [NW:0]        rem_shift;
   logic [NW+1:0]      diff;

   assign rem_shift = {rem_ff, 1'b0};
   assign diff      = {1'b0, rem_shift} - {2'b00, den_ff};

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(FRAC_W);
         den_in  = den;
         if (num >= den) begin
            rem_in = num - den;
            quo_in = SCORE_W'(1);
         end else begin
            rem_in = num;
            quo_in = '0;
         end
      end else if (busy_ff) begin
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
         end
         if (!diff[NW+1]) begin
            rem_in = diff[NW-1:0];
            quo_in = {quo_ff[SCORE_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[NW-1:0];
            quo_in = {quo_ff[SCORE_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule

>>> hw/rtl/jaccard_sorted_set_similarity_core.sv
// ----------------------------------------------------------------------------
// jaccard_sorted_set_similarity_core
// Pushes can be accepted back to back while the core is idle.
// A compare passes through the balance-check states ST_BAL and ST_CHK, one
// merge step per cycle against the two list memories, a divider start
// state, the bit-serial score divider and a load of the result register,
// which waits until any earlier result has been taken.
// A length-rejected or zero-overlap compare skips the divider.
// Synchronous reset clears the counts, the overflow flag, the result valid
// flag and restores both thresholds; list memories are not cleared.
// ----------------------------------------------------------------------------
module jaccard_sorted_set_similarity_core import jss_pkg::*; #(
   parameter int MAX_ELEMENTS = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   jss_req_if.sink                req_ch,
   jss_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam int TW = CW + 1;
   localparam int PW = SIM_W + TW;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_BAL  = 6'b000010,
      ST_CHK  = 6'b000100,
      ST_WALK = 6'b001000,
      ST_MUL  = 6'b010000,
      ST_DIV  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [TOKEN_W-1:0] list_a [MAX_ELEMENTS];
   logic [TOKEN_W-1:0] list_b [MAX_ELEMENTS];

   logic [CW-1:0]      cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic               ovf_ff, ovf_in;
   logic [BAL_W-1:0]   bal_ff;
   logic [SIM_W-1:0]   sim_ff;
   logic [CW-1:0]      i_ff, i_in, j_ff, j_in, inter_ff, inter_in;
   logic [TOKEN_W-1:0] a_rd_ff, b_rd_ff;
   logic [PW-1:0]      lo_prod_ff, hi_prod_ff, sim_prod_ff;
   logic               rej_ff, rej_in;
   logic               fin_ok;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SCORE_W-1:0]     rsp_score_ff, rsp_score_in;
   logic                   rsp_match_ff, rsp_match_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                   rsp_rej_ff, rsp_rej_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   logic [TW-1:0]      total, uni;
   logic [PW-1:0]      la_scaled, inter_scaled;
   logic [SIM_W-1:0]   hi_thresh;
   logic               req_xfer, rsp_xfer, div_start, div_busy;
   logic [SCORE_W-1:0] div_quo;

   assign total        = TW'(cnt_a_ff) + TW'(cnt_b_ff);
   assign uni          = total - TW'(inter_ff);
   assign la_scaled    = PW'({cnt_a_ff, {FRAC_W{1'b0}}});
   assign inter_scaled = PW'({inter_ff, {FRAC_W{1'b0}}});
   assign hi_thresh    = Q16_ONE - SIM_W'(bal_ff);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign rsp_xfer     = rsp_valid_ff && rsp_ch.ready;
   assign div_start    = (state_ff == ST_MUL);
   assign req_ch.ready = (state_ff == ST_IDLE);

   jss_div #(
      .NW (TW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (TW'(inter_ff)),
      .den   (uni),
      .busy  (div_busy),
      .quo   (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      inter_in     = inter_ff;
      rej_in       = rej_ff;
      fin_ok       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_xfer;
      rsp_score_in = rsp_score_ff;
      rsp_match_in = rsp_match_ff;
      rsp_count_in = rsp_count_ff;
      rsp_rej_in   = rsp_rej_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (opcode_type'(req_ch.opcode))
                  OP_PUSH_A: begin
                     if (cnt_a_ff != CW'(MAX_ELEMENTS)) begin
                        cnt_a_in = cnt_a_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  OP_PUSH_B: begin
                     if (cnt_b_ff != CW'(MAX_ELEMENTS)) begin
                        cnt_b_in = cnt_b_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  OP_COMPARE: begin
                     i_in     = '0;
                     j_in     = '0;
                     inter_in = '0;
                     state_in = ST_BAL;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_BAL: begin
            state_in = ST_CHK;
         end
         ST_CHK: begin
            rej_in = (la_scaled < lo_prod_ff) || (la_scaled > hi_prod_ff);
            state_in = (rej_in) ? ST_DIV : ST_WALK;
         end
         ST_WALK: begin
            if ((i_ff < cnt_a_ff) && (j_ff < cnt_b_ff)) begin
               if (a_rd_ff < b_rd_ff) begin
                  i_in = i_ff + 1'b1;
               end else if (b_rd_ff < a_rd_ff) begin
                  j_in = j_ff + 1'b1;
               end else begin
                  i_in     = i_ff + 1'b1;
                  j_in     = j_ff + 1'b1;
                  inter_in = inter_ff + 1'b1;
               end
            end else begin
               state_in = (inter_ff == '0) ? ST_DIV : ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!div_busy && (!rsp_valid_ff || rsp_ch.ready)) begin
               fin_ok = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (fin_ok) begin
         rsp_valid_in = 1'b1;
         rsp_rej_in   = rej_ff;
         rsp_ovf_in   = ovf_ff;
         rsp_count_in = COUNT_OUT_W'(inter_ff);
         if (rej_ff || (inter_ff == '0)) begin
            rsp_score_in = '0;
            rsp_match_in = 1'b0;
         end else begin
            rsp_score_in = div_quo;
            rsp_match_in = (inter_scaled > sim_prod_ff);
         end
         cnt_a_in = '0;
         cnt_b_in = '0;
         ovf_in   = 1'b0;
         rej_in   = 1'b0;
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         ovf_ff       <= 1'b0;
         rej_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bal_ff       <= BAL_RESET;
         sim_ff       <= SIM_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         ovf_ff       <= ovf_in;
         rej_ff       <= rej_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_BALANCE:    bal_ff <= csr_wdata[BAL_W-1:0];
               CSR_SIMILARITY: sim_ff <= csr_wdata[SIM_W-1:0];
               default: begin
               end
            endcase
         end
      end
      i_ff         <= i_in;
      j_ff         <= j_in;
      inter_ff     <= inter_in;
      lo_prod_ff   <= PW'(bal_ff) * PW'(total);
      hi_prod_ff   <= PW'(hi_thresh) * PW'(total);
      sim_prod_ff  <= PW'(sim_ff) * PW'(uni);
      rsp_score_ff <= rsp_score_in;
      rsp_match_ff <= rsp_match_in;
      rsp_count_ff <= rsp_count_in;
      rsp_rej_ff   <= rsp_rej_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // The read address follows the next walk index so that the registered
   // read data lines up with the current index on every merge step.
   always_ff @(posedge clock) begin
      if (req_xfer && (opcode_type'(req_ch.opcode) == OP_PUSH_A) &&
          (cnt_a_ff != CW'(MAX_ELEMENTS))) begin
         list_a[cnt_a_ff[AW-1:0]] <= req_ch.token;
      end
      if (req_xfer && (opcode_type'(req_ch.opcode) == OP_PUSH_B) &&
          (cnt_b_ff != CW'(MAX_ELEMENTS))) begin
         list_b[cnt_b_ff[AW-1:0]] <= req_ch.token;
      end
      a_rd_ff <= list_a[i_in[AW-1:0]];
      b_rd_ff <= list_b[j_in[AW-1:0]];
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.score           = rsp_score_ff;
   assign rsp_ch.match           = rsp_match_ff;
   assign rsp_ch.common_count    = rsp_count_ff;
   assign rsp_ch.length_rejected = rsp_rej_ff;
   assign rsp_ch.overflowed      = rsp_ovf_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_a_ff <= CW'(MAX_ELEMENTS)) && (cnt_b_ff <= CW'(MAX_ELEMENTS)))
      else $error("list count beyond capacity");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (i_ff <= cnt_a_ff) && (j_ff <= cnt_b_ff) &&
                                (inter_ff <= i_ff) && (inter_ff <= j_ff))
      else $error("merge walk index out of range");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DIV))
      else $error("result raised outside the final compare step");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_rej_ff) |->
         (rsp_score_ff == '0) && (rsp_count_ff == '0) && !rsp_match_ff)
      else $error("rejected compare with nonzero fields");

   a_counts_cleared: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (cnt_a_ff == '0) && (cnt_b_ff == '0) && !ovf_ff)
      else $error("lists not cleared after compare");
`endif

endmodule
